[rtl/adsr_pkg.sv]
// ---------------------------------------------------------------------------
// adsr_pkg
// Shared types, codes and the exponential curve table of the envelope block.
// ---------------------------------------------------------------------------
package adsr_pkg;

  localparam int unsigned LEVEL_W  = 10;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned CFG_IW   = 2;
  localparam int unsigned CFG_DW   = 16;
  // Curve table: 256 entries, index is count * 255 / time
  localparam int unsigned CURVE_DEPTH = 256;
  localparam int unsigned CURVE_AW    = $clog2(CURVE_DEPTH);
  localparam int unsigned PROD_W      = 2 * LEVEL_W;

  localparam logic [LEVEL_W-1:0] FULL_SCALE = 10'd1023;

  // Envelope phases
  localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd3;
  localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_ATTACK  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_DECAY   = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_SUSTAIN = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_RELEASE = 2'd3;

  // Configuration reset values
  localparam logic [COUNT_W-1:0] ATTACK_RST  = 16'd200;
  localparam logic [COUNT_W-1:0] DECAY_RST   = 16'd2000;
  localparam logic [LEVEL_W-1:0] SUSTAIN_RST = 10'd500;
  localparam logic [COUNT_W-1:0] RELEASE_RST = 16'd1000;

  // One envelope state record
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [COUNT_W-1:0] count;
    logic [LEVEL_W-1:0] held;
    logic [LEVEL_W-1:0] level;
  } env_state_t;

  localparam env_state_t ENV_RST = '{phase: PH_IDLE, count: '0, held: '0, level: '0};

  localparam logic [LEVEL_W-1:0] EXP_ROM [CURVE_DEPTH] = '{
    10'd0,    10'd19,   10'd39,   10'd58,   10'd77,   10'd95,   10'd113,  10'd131,
    10'd148,  10'd165,  10'd182,  10'd198,  10'd214,  10'd230,  10'd245,  10'd260,
    10'd275,  10'd289,  10'd304,  10'd318,  10'd331,  10'd345,  10'd358,  10'd371,
    10'd383,  10'd396,  10'd408,  10'd420,  10'd432,  10'd443,  10'd454,  10'd465,
    10'd476,  10'd487,  10'd497,  10'd507,  10'd517,  10'd527,  10'd537,  10'd546,
    10'd556,  10'd565,  10'd574,  10'd582,  10'd591,  10'd599,  10'd607,  10'd615,
    10'd623,  10'd631,  10'd639,  10'd646,  10'd653,  10'd661,  10'd668,  10'd675,
    10'd681,  10'd688,  10'd694,  10'd701,  10'd707,  10'd713,  10'd719,  10'd725,
    10'd731,  10'd737,  10'd742,  10'd748,  10'd753,  10'd758,  10'd763,  10'd768,
    10'd773,  10'd778,  10'd783,  10'd787,  10'd792,  10'd796,  10'd801,  10'd805,
    10'd809,  10'd814,  10'd818,  10'd822,  10'd825,  10'd829,  10'd833,  10'd837,
    10'd840,  10'd844,  10'd847,  10'd851,  10'd854,  10'd857,  10'd861,  10'd864,
    10'd867,  10'd870,  10'd873,  10'd876,  10'd879,  10'd881,  10'd884,  10'd887,
    10'd889,  10'd892,  10'd894,  10'd897,  10'd899,  10'd902,  10'd904,  10'd906,
    10'd909,  10'd911,  10'd913,  10'd915,  10'd917,  10'd919,  10'd921,  10'd923,
    10'd925,  10'd927,  10'd929,  10'd931,  10'd933,  10'd934,  10'd936,  10'd938,
    10'd939,  10'd941,  10'd943,  10'd944,  10'd946,  10'd947,  10'd949,  10'd950,
    10'd951,  10'd953,  10'd954,  10'd955,  10'd957,  10'd958,  10'd959,  10'd961,
    10'd962,  10'd963,  10'd964,  10'd965,  10'd966,  10'd967,  10'd968,  10'd970,
    10'd971,  10'd972,  10'd973,  10'd974,  10'd974,  10'd975,  10'd976,  10'd977,
    10'd978,  10'd979,  10'd980,  10'd981,  10'd981,  10'd982,  10'd983,  10'd984,
    10'd985,  10'd985,  10'd986,  10'd987,  10'd987,  10'd988,  10'd989,  10'd989,
    10'd990,  10'd991,  10'd991,  10'd992,  10'd993,  10'd993,  10'd994,  10'd994,
    10'd995,  10'd995,  10'd996,  10'd996,  10'd997,  10'd997,  10'd998,  10'd998,
    10'd999,  10'd999,  10'd1000, 10'd1000, 10'd1001, 10'd1001, 10'd1001, 10'd1002,
    10'd1002, 10'd1003, 10'd1003, 10'd1003, 10'd1004, 10'd1004, 10'd1004, 10'd1005,
    10'd1005, 10'd1006, 10'd1006, 10'd1006, 10'd1006, 10'd1007, 10'd1007, 10'd1007,
    10'd1008, 10'd1008, 10'd1008, 10'd1009, 10'd1009, 10'd1009, 10'd1009, 10'd1010,
    10'd1010, 10'd1010, 10'd1010, 10'd1011, 10'd1011, 10'd1011, 10'd1011, 10'd1011,
    10'd1012, 10'd1012, 10'd1012, 10'd1012, 10'd1012, 10'd1013, 10'd1013, 10'd1013,
    10'd1013, 10'd1013, 10'd1014, 10'd1014, 10'd1014, 10'd1014, 10'd1014, 10'd1014,
    10'd1015, 10'd1015, 10'd1015, 10'd1015, 10'd1015, 10'd1015, 10'd1015, 10'd1016
  };

endpackage

[rtl/adsr_envelope_generator_top.sv]
// Results: every tick gives one result once accepted, whether it steps a curve or
//   handles idle, sustain or a phase end; a gate edge item gives none.
// Flow: items run one at a time, a new one taken only after the last is through
//   write back; the 8-step serial curve-index divider lengthens decay, release and
//   attack ticks, and a stalled result holds a tick item in write back.
// Reset (rst_n low, synchronous): phase idle, counter and levels zero, timing
//   registers back to 200 / 2000 / 500 / 1000, no result pending.
// ---------------------------------------------------------------------------
// adsr_envelope_generator_top
// ADSR envelope generator: gate edges start attack or release, ticks step the
// envelope, along an exponential curve table in attack, decay and release, and each emit one 10-bit level.
// ---------------------------------------------------------------------------
module adsr_envelope_generator_top
  import adsr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic               in_gate_level,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic [LEVEL_W-1:0] out_envelope_level,
  // configuration writes
  input  logic               cfg_we,
  input  logic [CFG_IW-1:0]  cfg_index,
  input  logic [CFG_DW-1:0]  cfg_wdata
);

  // Sequencer codes
  localparam logic [2:0] ST_IDLE   = 3'd0; // wait for an item
  localparam logic [2:0] ST_LOAD   = 3'd1; // take the state record from memory
  localparam logic [2:0] ST_DECIDE = 3'd2; // pick the phase work
  localparam logic [2:0] ST_DIV    = 3'd3; // one quotient bit per cycle
  localparam logic [2:0] ST_ROM    = 3'd4; // curve table read
  localparam logic [2:0] ST_MUL    = 3'd5; // level scaling product, or the attack level
  localparam logic [2:0] ST_SCALE  = 3'd6; // divide by full scale
  localparam logic [2:0] ST_EMIT   = 3'd7; // write back, present result

  localparam int unsigned STEP_W = $clog2(CURVE_AW);

  // Configuration registers
  logic [COUNT_W-1:0] attack_ticks_r;
  logic [COUNT_W-1:0] decay_ticks_r;
  logic [LEVEL_W-1:0] sustain_level_r;
  logic [COUNT_W-1:0] release_ticks_r;

  // Envelope state memory: a single record, read every cycle through a register.
  // The valid bit stands in for the reset value until the first write back.
  env_state_t         state_mem [1];
  env_state_t         st_rd_r;
  logic               st_valid_r;
  logic               mem_we;
  env_state_t         mem_wdata;

  // Sequencer and working registers
  logic [2:0]          seq_r,   seq_nxt;
  logic                tick_r,  tick_nxt;
  logic                gate_r,  gate_nxt;
  logic [PHASE_W-1:0]  ph_r,    ph_nxt;
  logic [COUNT_W-1:0]  cnt_r,   cnt_nxt;
  logic [LEVEL_W-1:0]  held_r,  held_nxt;
  logic [LEVEL_W-1:0]  lvl_r,   lvl_nxt;
  logic [COUNT_W-1:0]  div_r,   div_nxt;
  logic [COUNT_W-1:0]  rem_r,   rem_nxt;
  logic [CURVE_AW-1:0] quot_r,  quot_nxt;
  logic [STEP_W-1:0]   step_r,  step_nxt;
  logic [PROD_W-1:0]   prod_r,  prod_nxt;
  logic [LEVEL_W-1:0]  curve_r;
  logic                out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0]  out_level_r, out_level_nxt;

  // Datapath helpers
  logic [COUNT_W+CURVE_AW-1:0] idx_num;    // count * 255
  logic [COUNT_W:0]            trial;
  logic [COUNT_W:0]            trial_diff;
  logic                        trial_ge;
  logic [COUNT_W-1:0]          phase_time;
  logic [LEVEL_W-1:0]          inv_curve;
  logic [LEVEL_W-1:0]          mul_a;
  logic [LEVEL_W-1:0]          q_hi;
  logic [LEVEL_W:0]            q_rem;
  logic [LEVEL_W-1:0]          q_fs;       // prod / 1023
  logic                        slot_free;
  logic                        emit_ok;

  // -------------------------------------------------------------------------
  // Configuration port: write only while no item is in work.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_ticks_r  <= ATTACK_RST;
      decay_ticks_r   <= DECAY_RST;
      sustain_level_r <= SUSTAIN_RST;
      release_ticks_r <= RELEASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ATTACK:  attack_ticks_r  <= cfg_wdata;
        CFG_DECAY:   decay_ticks_r   <= cfg_wdata;
        CFG_SUSTAIN: sustain_level_r <= cfg_wdata[LEVEL_W-1:0];
        CFG_RELEASE: release_ticks_r <= cfg_wdata;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // State memory: one write port, registered read. Items run one at a time
  // and the next acceptance is never earlier than the cycle after write back, so the read
  // register always carries the latest record by the time it is loaded.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      state_mem[0] <= mem_wdata;
    end
    st_rd_r <= state_mem[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (mem_we) begin
      st_valid_r <= 1'b1;
    end
  end

  // Curve table read, registered; the address is the finished quotient
  always_ff @(posedge clk) begin
    curve_r <= EXP_ROM[quot_r];
  end

  // -------------------------------------------------------------------------
  // Datapath
  // -------------------------------------------------------------------------
  // count * 255 as (count << 8) - count
  assign idx_num = {cnt_r, {CURVE_AW{1'b0}}} - {{CURVE_AW{1'b0}}, cnt_r};

  // Restoring division step: bring in the next numerator bit, held in quot_r
  assign trial      = {rem_r, quot_r[CURVE_AW-1]};
  assign trial_diff = trial - {1'b0, div_r};
  assign trial_ge   = (trial >= {1'b0, div_r});

  always_comb begin
    case (ph_r)
      PH_ATTACK: phase_time = attack_ticks_r;
      PH_DECAY:  phase_time = decay_ticks_r;
      default:   phase_time = release_ticks_r;
    endcase
  end

  // Decay scales the distance to the sustain floor; release scales the held level
  assign inv_curve = FULL_SCALE - curve_r;
  assign mul_a     = (ph_r == PH_DECAY) ? (FULL_SCALE - sustain_level_r) : held_r;

  // prod / 1023: prod = hi*1023 + (hi + lo), and hi + lo stays below 2*1023
  assign q_hi  = prod_r[PROD_W-1:LEVEL_W];
  assign q_rem = {1'b0, prod_r[LEVEL_W-1:0]} + {1'b0, q_hi};
  assign q_fs  = q_hi + ((q_rem >= {1'b0, FULL_SCALE}) ? 10'd1 : 10'd0);

  // Result register is free when empty or being taken this cycle
  assign slot_free = !out_valid_r || !out_stall;
  assign emit_ok   = !tick_r || slot_free;

  assign mem_we    = (seq_r == ST_EMIT) && emit_ok;
  assign mem_wdata = '{phase: ph_r,
                       count: tick_r ? (cnt_r + 16'd1) : cnt_r,
                       held:  held_r,
                       level: lvl_r};

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    seq_nxt       = seq_r;
    tick_nxt      = tick_r;
    gate_nxt      = gate_r;
    ph_nxt        = ph_r;
    cnt_nxt       = cnt_r;
    held_nxt      = held_r;
    lvl_nxt       = lvl_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    quot_nxt      = quot_r;
    step_nxt      = step_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_level_nxt = out_level_r;

    unique case (seq_r)
      ST_IDLE: begin
        if (in_valid) begin
          tick_nxt = !in_opcode;
          gate_nxt = in_gate_level;
          seq_nxt  = ST_LOAD;
        end
      end

      ST_LOAD: begin
        if (st_valid_r) begin
          ph_nxt   = st_rd_r.phase;
          cnt_nxt  = st_rd_r.count;
          held_nxt = st_rd_r.held;
          lvl_nxt  = st_rd_r.level;
        end else begin
          ph_nxt   = ENV_RST.phase;
          cnt_nxt  = ENV_RST.count;
          held_nxt = ENV_RST.held;
          lvl_nxt  = ENV_RST.level;
        end
        seq_nxt = ST_DECIDE;
      end

      ST_DECIDE: begin
        seq_nxt = ST_EMIT;
        if (!tick_r) begin
          // gate edge: restart the counter in attack or release
          ph_nxt  = gate_r ? PH_ATTACK : PH_RELEASE;
          cnt_nxt = '0;
        end else begin
          case (ph_r) inside
            PH_ATTACK, PH_DECAY, PH_RELEASE: begin
              if (cnt_r < phase_time) begin
                // curve index = count*255/time, below 255 since count < time
                div_nxt  = phase_time;
                rem_nxt  = idx_num[COUNT_W+CURVE_AW-1:CURVE_AW];
                quot_nxt = idx_num[CURVE_AW-1:0];
                step_nxt = '0;
                seq_nxt  = ST_DIV;
              end else if (ph_r == PH_ATTACK) begin
                ph_nxt  = PH_DECAY;
                cnt_nxt = '0;
              end else if (ph_r == PH_DECAY) begin
                ph_nxt  = PH_SUSTAIN;
                cnt_nxt = '0;
              end else begin
                ph_nxt  = PH_IDLE;
                lvl_nxt = '0;
              end
            end
            PH_SUSTAIN: begin
              held_nxt = sustain_level_r;
              lvl_nxt  = sustain_level_r;
            end
            default: begin
              lvl_nxt = '0;
            end
          endcase
        end
      end

      ST_DIV: begin
        rem_nxt  = trial_ge ? trial_diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
        quot_nxt = {quot_r[CURVE_AW-2:0], trial_ge};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(CURVE_AW - 1)) begin
          seq_nxt = ST_ROM;
        end
      end

      ST_ROM: begin
        seq_nxt = ST_MUL;
      end

      ST_MUL: begin
        if (ph_r == PH_ATTACK) begin
          held_nxt = curve_r;
          lvl_nxt  = curve_r;
          seq_nxt  = ST_EMIT;
        end else begin
          prod_nxt = mul_a * inv_curve;
          seq_nxt  = ST_SCALE;
        end
      end

      ST_SCALE: begin
        if (ph_r == PH_DECAY) begin
          held_nxt = sustain_level_r + q_fs;
          lvl_nxt  = sustain_level_r + q_fs;
        end else begin
          lvl_nxt = q_fs;
        end
        seq_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        // hold until the result register can take the level
        if (emit_ok) begin
          if (tick_r) begin
            out_valid_nxt = 1'b1;
            out_level_nxt = lvl_r;
          end
          seq_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tick_r      <= tick_nxt;
    gate_r      <= gate_nxt;
    ph_r        <= ph_nxt;
    cnt_r       <= cnt_nxt;
    held_r      <= held_nxt;
    lvl_r       <= lvl_nxt;
    div_r       <= div_nxt;
    rem_r       <= rem_nxt;
    quot_r      <= quot_nxt;
    step_r      <= step_nxt;
    prod_r      <= prod_nxt;
    out_level_r <= out_level_nxt;
  end

  assign in_stall           = (seq_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_envelope_level = out_level_r;

endmodule

[rtl/adsr_chk.sv]
// ---------------------------------------------------------------------------
// adsr_chk
// Port-level checks on the envelope generator, attached by bind.
// ---------------------------------------------------------------------------
module adsr_chk
  import adsr_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [LEVEL_W-1:0] out_envelope_level
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_envelope_level))
    else $error("stalled result item changed or dropped");

  // Items run one at a time: busy straight after an acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while first still in work");

  // A new result only comes out of work in progress
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result item appeared without an item in work");

  // Reset leaves the block ready and empty
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind adsr_envelope_generator_top adsr_chk u_adsr_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_envelope_level (out_envelope_level)
);
